### rtl/core/fbfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fbfl_pkg;

   localparam int SLOTS  = 64;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LINK_W = SLOT_W + 1;

   localparam logic [LINK_W-1:0] LINK_END = LINK_W'(SLOTS);

   typedef enum logic [1:0] {
      ACT_TAKE  = 2'd0,
      ACT_PUT   = 2'd1,
      ACT_RESET = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_DONE   = 2'd0,
      STS_EMPTY  = 2'd1,
      STS_REJECT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUILD,
      ST_POP
   } state_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [LINK_W-1:0] data;
   } link_wr_type;

endpackage
`default_nettype wire

### rtl/core/fbfl_link_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Next-link store, one write and one registered read per cycle.
module fbfl_link_ram (
   input  wire logic                          clock,
   input  wire fbfl_pkg::link_wr_type         wr,
   input  wire logic                          rd_en,
   input  wire logic [fbfl_pkg::SLOT_W-1:0]   rd_addr,
   output logic      [fbfl_pkg::LINK_W-1:0]   rd_data
);

   logic [fbfl_pkg::LINK_W-1:0] mem [fbfl_pkg::SLOTS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

### rtl/core/fixed_block_free_list_pool.sv
`timescale 1ns / 1ps
`default_nettype none
// Put, empty take, unbuilt pool reset and no-op give their beat in the cycle after accept.
// A take that pops a free slot reads the link store: busy in ST_POP, beat registered from ST_POP.
// First take and a built pool reset walk the store one entry per cycle in ST_BUILD over the latched
// pool size (slot_count clamped to 1..64 at the first take); beat in the cycle after the walk ends.
// Throughput: one item a cycle while not busy; the receiver cannot stall the result beat.
// Reset (sync, active high): pool unbuilt, head empty, slot_count 64; link store left as it is.
module fixed_block_free_list_pool (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_action,
   input  wire logic [fbfl_pkg::SLOT_W-1:0]  req_slot,
   output logic                              rsp_valid,
   output logic      [fbfl_pkg::SLOT_W-1:0]  rsp_granted_slot,
   output logic      [1:0]                   rsp_status,
   input  wire logic                         csr_wr_en,
   input  wire logic [fbfl_pkg::LINK_W-1:0]  csr_wr_data
);

   // control state
   fbfl_pkg::state_type           state_ff, state_in;
   logic [fbfl_pkg::LINK_W-1:0]   head_ff, head_in;        // SLOTS means empty
   logic                          built_ff, built_in;
   logic [fbfl_pkg::LINK_W-1:0]   count_ff, count_in;      // slots latched at build
   logic [fbfl_pkg::SLOT_W-1:0]   idx_ff, idx_in;          // walk position
   logic                          take_pend_ff, take_pend_in;
   logic [fbfl_pkg::LINK_W-1:0]   csr_slot_count_ff;

   // result beat
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fbfl_pkg::SLOT_W-1:0]   granted_ff, granted_in;
   fbfl_pkg::status_type          status_ff, status_in;

   // link store access
   fbfl_pkg::link_wr_type         link_wr;
   logic                          rd_en;
   logic [fbfl_pkg::LINK_W-1:0]   rd_data;
   logic [fbfl_pkg::LINK_W-1:0]   sat_count;
   logic                          walk_last;

   fbfl_link_ram u_link_ram (
      .clock   (clock),
      .wr      (link_wr),
      .rd_en   (rd_en),
      .rd_addr (head_ff[fbfl_pkg::SLOT_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_slot_count_ff <= fbfl_pkg::LINK_END;
      end else if (csr_wr_en) begin
         csr_slot_count_ff <= csr_wr_data;
      end
   end

   // slot_count clamped to 1..SLOTS when the chain is first built
   always_comb begin
      if (csr_slot_count_ff == '0) begin
         sat_count = fbfl_pkg::LINK_W'(1);
      end else if (csr_slot_count_ff > fbfl_pkg::LINK_END) begin
         sat_count = fbfl_pkg::LINK_END;
      end else begin
         sat_count = csr_slot_count_ff;
      end
   end

   assign walk_last = ({1'b0, idx_ff} == count_ff - fbfl_pkg::LINK_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbfl_pkg::ST_IDLE;
         head_ff      <= fbfl_pkg::LINK_END;
         built_ff     <= 1'b0;
         count_ff     <= '0;
         idx_ff       <= '0;
         take_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         built_ff     <= built_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         take_pend_ff <= take_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      granted_ff <= granted_in;
      status_ff  <= status_in;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      built_in     = built_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      take_pend_in = take_pend_ff;
      rsp_valid_in = 1'b0;
      granted_in   = '0;
      status_in    = fbfl_pkg::STS_DONE;
      link_wr      = '0;
      rd_en        = 1'b0;

      case (state_ff)
         fbfl_pkg::ST_IDLE: begin
            if (start) begin
               case (fbfl_pkg::action_type'(req_action))
                  fbfl_pkg::ACT_TAKE: begin
                     if (!built_ff) begin
                        // lazy build: walk the chain, then hand out slot 0
                        built_in     = 1'b1;
                        count_in     = sat_count;
                        idx_in       = '0;
                        take_pend_in = 1'b1;
                        state_in     = fbfl_pkg::ST_BUILD;
                     end else if (head_ff == fbfl_pkg::LINK_END) begin
                        rsp_valid_in = 1'b1;
                        status_in    = fbfl_pkg::STS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = fbfl_pkg::ST_POP;
                     end
                  end
                  fbfl_pkg::ACT_PUT: begin
                     rsp_valid_in = 1'b1;
                     if (!built_ff || {1'b0, req_slot} >= count_ff) begin
                        status_in = fbfl_pkg::STS_REJECT;
                     end else begin
                        link_wr.en   = 1'b1;
                        link_wr.addr = req_slot;
                        link_wr.data = head_ff;
                        head_in      = {1'b0, req_slot};
                     end
                  end
                  fbfl_pkg::ACT_RESET: begin
                     if (built_ff) begin
                        idx_in       = '0;
                        take_pend_in = 1'b0;
                        state_in     = fbfl_pkg::ST_BUILD;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         fbfl_pkg::ST_BUILD: begin
            link_wr.en   = 1'b1;
            link_wr.addr = idx_ff;
            link_wr.data = walk_last ? fbfl_pkg::LINK_END
                                     : fbfl_pkg::LINK_W'(idx_ff) + fbfl_pkg::LINK_W'(1);
            idx_in = idx_ff + fbfl_pkg::SLOT_W'(1);
            if (walk_last) begin
               rsp_valid_in = 1'b1;
               state_in     = fbfl_pkg::ST_IDLE;
               // a pending take pops slot 0 at once; its link is 1, or end for a single slot
               if (take_pend_ff) begin
                  head_in = (count_ff == fbfl_pkg::LINK_W'(1)) ? fbfl_pkg::LINK_END
                                                               : fbfl_pkg::LINK_W'(1);
               end else begin
                  head_in = '0;
               end
            end
         end
         fbfl_pkg::ST_POP: begin
            rsp_valid_in = 1'b1;
            granted_in   = head_ff[fbfl_pkg::SLOT_W-1:0];
            head_in      = rd_data;
            state_in     = fbfl_pkg::ST_IDLE;
         end
         default: begin
            state_in = fbfl_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != fbfl_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = granted_ff;
   assign rsp_status       = status_ff;

   // a beat that is not a plain done carries no slot
   a_no_slot_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != fbfl_pkg::STS_DONE |-> rsp_granted_slot == '0)
      else $error("slot granted on failed beat");

   // head is either empty or a slot inside the built pool
   a_head_in_pool: assert property (@(posedge clock) disable iff (reset)
      head_ff == fbfl_pkg::LINK_END || head_ff < count_ff)
      else $error("free head outside pool");

   // walking the chain only once the pool size is latched
   a_walk_built: assert property (@(posedge clock) disable iff (reset)
      state_ff == fbfl_pkg::ST_BUILD |-> built_ff && count_ff != '0)
      else $error("chain walk without latched size");

   // a put never needs the store read, so its beat follows straight away
   a_put_beat: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action == fbfl_pkg::ACT_PUT |=> rsp_valid && !busy)
      else $error("put beat missing");

   // a pop beat follows the link read
   a_pop_beat: assert property (@(posedge clock) disable iff (reset)
      state_ff == fbfl_pkg::ST_POP |=> rsp_valid && rsp_status == fbfl_pkg::STS_DONE)
      else $error("pop beat missing");

endmodule
`default_nettype wire
